[rtl/hslc_pkg.sv]
// ---------------------------------------------------------------------------
// hslc_pkg
// shared types and constants of the hsl pixel classifier
// ---------------------------------------------------------------------------
`default_nettype none

package hslc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // register reset values
  localparam logic [7:0]        RstSatFloor     = 8'd33;
  localparam logic [7:0]        RstLightFloor   = 8'd38;
  localparam logic [7:0]        RstOrangeSatMin = 8'd110;
  localparam logic signed [9:0] RstRedHueLow    = -10'sd40;
  localparam logic signed [9:0] RstOrangeHueLow = 10'sd11;
  localparam logic signed [9:0] RstOrangeHueHi  = 10'sd40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAT_FLOOR       = 3'd0,
    REG_LIGHT_FLOOR     = 3'd1,
    REG_ORANGE_SAT_MIN  = 3'd2,
    REG_RED_HUE_LOW     = 3'd3,
    REG_ORANGE_HUE_LOW  = 3'd4,
    REG_ORANGE_HUE_HIGH = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLASS_KEEP  = 2'd0,
    CLASS_WHITE = 2'd1,
    CLASS_BLACK = 2'd2
  } pixel_class_t;

  typedef enum logic [1:0] {
    MAX_BLUE  = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_RED   = 2'd2
  } max_sel_t;

  typedef struct packed {
    logic [7:0]        sat_floor;
    logic [7:0]        light_floor;
    logic [7:0]        orange_sat_min;
    logic signed [9:0] red_hue_low;
    logic signed [9:0] orange_hue_low;
    logic signed [9:0] orange_hue_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // stage 1: extremes and the channel difference for the hue
  typedef struct packed {
    pix_t              pix;
    logic [7:0]        mx;
    logic [7:0]        mn;
    max_sel_t          sel;
    logic signed [8:0] diff;
  } s1_t;

  // stage 2: chroma, sum, saturation divisor, hue as hn/hd
  typedef struct packed {
    pix_t               pix;
    logic               grey;
    logic [7:0]         d;
    logic [8:0]         sum;
    logic [7:0]         den;
    logic signed [17:0] hn;
    logic [7:0]         hd;
  } s2_t;

  // stage 3: cross products against the thresholds
  typedef struct packed {
    pix_t               pix;
    logic               grey;
    logic [7:0]         d;
    logic [8:0]         sum;
    logic signed [17:0] hn;
    logic [15:0]        prod_sat;
    logic [15:0]        prod_osm;
    logic [16:0]        prod_light;
    logic signed [18:0] p_oh;
    logic signed [18:0] p_rl;
    logic signed [18:0] p_ol;
  } s3_t;

endpackage

`default_nettype wire

[rtl/hslc_if.sv]
// ---------------------------------------------------------------------------
// hslc_if
// valid/ready channels for input pixels and classified pixels
// ---------------------------------------------------------------------------
`default_nettype none

interface hslc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  input ready);
  modport sink   (input valid, input in_blue, input in_green, input in_red,
                  output ready);
endinterface

interface hslc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [1:0] pixel_class;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output pixel_class, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input pixel_class, output ready);
endinterface

`default_nettype wire

[rtl/hslc_decide.sv]
// ---------------------------------------------------------------------------
// hslc_decide
// threshold compares and the white / black / keep decision
// ---------------------------------------------------------------------------
`default_nettype none

module hslc_decide
  import hslc_pkg::*;
(
  input  s3_t          s3,
  input  cfg_t         cfg,
  output pixel_class_t cls
);

  logic [15:0]        d256;
  logic [16:0]        sum256;
  logic signed [18:0] hn;
  logic               sat_low;
  logic               light_low;
  logic               sat_orange;
  logic               above;
  logic               ge_rl;
  logic               ge_ol;

  always_comb begin
    d256       = {s3.d, 8'd0};
    sum256     = {s3.sum, 8'd0};
    hn         = 19'($signed(s3.hn));
    sat_low    = s3.grey ? (cfg.sat_floor != 8'd0) : (d256 < s3.prod_sat);
    light_low  = sum256 < s3.prod_light;
    sat_orange = s3.grey ? (cfg.orange_sat_min == 8'd0) : (d256 >= s3.prod_osm);
    // hue never exceeds 300 degrees, so the 360 upper bound always holds
    above      = hn > $signed(s3.p_oh);
    ge_rl      = hn >= $signed(s3.p_rl);
    ge_ol      = hn >= $signed(s3.p_ol);

    if (sat_low || light_low) begin
      cls = CLASS_WHITE;
    end else if (above) begin
      cls = CLASS_BLACK;
    end else if (ge_rl && !ge_ol) begin
      cls = CLASS_BLACK;
    end else if (ge_ol) begin
      cls = sat_orange ? CLASS_BLACK : CLASS_WHITE;
    end else begin
      cls = CLASS_KEEP;
    end
  end

endmodule

`default_nettype wire

[rtl/hsl_color_pixel_classifier.sv]
// ---------------------------------------------------------------------------
// hsl_color_pixel_classifier
// bgr pixel to hsl, thresholded into kept, forced white or forced black
// ---------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  in_pix    in    valid/ready    in_blue, in_green, in_red
//  out_pix   out   valid/ready    out_blue, out_green, out_red, pixel_class
//  cfg_*     in    cfg_we only    cfg_idx (register), cfg_wdata (10 bit)
//
//  one word per clock sustained while out_pix is not stalled; a word passes
//  through the four register stages: extremes, hue numerator,
//  threshold products, output register
//  each stage holds its own valid bit and loads when empty or when the
//  next one moves, so bubbles close up while the output is stalled
//  rst_n (synchronous) clears the valid bits and reloads the configuration registers
//
`default_nettype none

module hsl_color_pixel_classifier
  import hslc_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  hslc_in_if.sink            in_pix,
  hslc_out_if.source         out_pix,
  input  wire                cfg_we,
  input  wire [CfgIdxW-1:0]  cfg_idx,
  input  wire [CfgDataW-1:0] cfg_wdata
);

  // configuration registers
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_SAT_FLOOR:       cfg_nxt.sat_floor       = cfg_wdata[7:0];
        REG_LIGHT_FLOOR:     cfg_nxt.light_floor     = cfg_wdata[7:0];
        REG_ORANGE_SAT_MIN:  cfg_nxt.orange_sat_min  = cfg_wdata[7:0];
        REG_RED_HUE_LOW:     cfg_nxt.red_hue_low     = $signed(cfg_wdata);
        REG_ORANGE_HUE_LOW:  cfg_nxt.orange_hue_low  = $signed(cfg_wdata);
        REG_ORANGE_HUE_HIGH: cfg_nxt.orange_hue_high = $signed(cfg_wdata);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sat_floor       <= RstSatFloor;
      cfg_r.light_floor     <= RstLightFloor;
      cfg_r.orange_sat_min  <= RstOrangeSatMin;
      cfg_r.red_hue_low     <= RstRedHueLow;
      cfg_r.orange_hue_low  <= RstOrangeHueLow;
      cfg_r.orange_hue_high <= RstOrangeHueHi;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline flow control: a stage moves when empty or when its successor moves
  logic v1_r, v2_r, v3_r, vo_r;
  logic en1, en2, en3, en_o;

  assign en_o = !vo_r || out_pix.ready;
  assign en3  = !v3_r || en_o;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;

  assign in_pix.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1)  v1_r <= in_pix.valid;
      if (en2)  v2_r <= v1_r;
      if (en3)  v3_r <= v2_r;
      if (en_o) vo_r <= v3_r;
    end
  end

  // stage 1: max, min, winning channel (blue, then green, then red)
  s1_t s1_r, s1_nxt;

  always_comb begin
    s1_nxt.pix.blue  = in_pix.in_blue;
    s1_nxt.pix.green = in_pix.in_green;
    s1_nxt.pix.red   = in_pix.in_red;

    s1_nxt.mx = in_pix.in_blue;
    if (in_pix.in_green > s1_nxt.mx) s1_nxt.mx = in_pix.in_green;
    if (in_pix.in_red   > s1_nxt.mx) s1_nxt.mx = in_pix.in_red;
    s1_nxt.mn = in_pix.in_blue;
    if (in_pix.in_green < s1_nxt.mn) s1_nxt.mn = in_pix.in_green;
    if (in_pix.in_red   < s1_nxt.mn) s1_nxt.mn = in_pix.in_red;

    if (in_pix.in_blue == s1_nxt.mx) begin
      s1_nxt.sel  = MAX_BLUE;
      s1_nxt.diff = $signed({1'b0, in_pix.in_red}) - $signed({1'b0, in_pix.in_green});
    end else if (in_pix.in_green == s1_nxt.mx) begin
      s1_nxt.sel  = MAX_GREEN;
      s1_nxt.diff = $signed({1'b0, in_pix.in_blue}) - $signed({1'b0, in_pix.in_red});
    end else begin
      s1_nxt.sel  = MAX_RED;
      s1_nxt.diff = $signed({1'b0, in_pix.in_green}) - $signed({1'b0, in_pix.in_blue});
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
  end

  // stage 2: chroma, sum, saturation divisor and hue = hn / hd in degrees
  s2_t s2_r, s2_nxt;
  logic signed [17:0] d_s;
  logic signed [17:0] diff_s;
  logic signed [17:0] base;

  always_comb begin
    s2_nxt.pix  = s1_r.pix;
    s2_nxt.d    = s1_r.mx - s1_r.mn;
    s2_nxt.sum  = 9'(s1_r.mx) + 9'(s1_r.mn);
    // lightness below one half divides by sum, otherwise by 510 - sum
    s2_nxt.den  = (s2_nxt.sum < 9'd255) ? s2_nxt.sum[7:0] : 8'(9'd510 - s2_nxt.sum);
    s2_nxt.grey = (s2_nxt.d == 8'd0);

    d_s    = $signed(18'(s2_nxt.d));
    diff_s = 18'(s1_r.diff);
    case (s1_r.sel)
      MAX_BLUE:  base = 18'(d_s * 18'sd240);
      MAX_GREEN: base = 18'(d_s * 18'sd120);
      default:   base = 18'sd0;
    endcase

    // grey: hue taken as zero over a unit divisor
    s2_nxt.hn = s2_nxt.grey ? 18'sd0 : 18'(base + 18'(diff_s * 18'sd60));
    s2_nxt.hd = s2_nxt.grey ? 8'd1 : s2_nxt.d;
  end

  always_ff @(posedge clk) begin
    if (en2) s2_r <= s2_nxt;
  end

  // stage 3: multiply thresholds into the divisors so compares stay exact
  s3_t s3_r, s3_nxt;
  logic signed [18:0] hd_s;

  always_comb begin
    hd_s              = $signed(19'(s2_r.hd));
    s3_nxt.pix        = s2_r.pix;
    s3_nxt.grey       = s2_r.grey;
    s3_nxt.d          = s2_r.d;
    s3_nxt.sum        = s2_r.sum;
    s3_nxt.hn         = s2_r.hn;
    s3_nxt.prod_sat   = 16'(cfg_r.sat_floor) * 16'(s2_r.den);
    s3_nxt.prod_osm   = 16'(cfg_r.orange_sat_min) * 16'(s2_r.den);
    s3_nxt.prod_light = 17'(cfg_r.light_floor) * 17'd510;
    s3_nxt.p_oh       = 19'(19'(cfg_r.orange_hue_high) * hd_s);
    s3_nxt.p_rl       = 19'(19'(cfg_r.red_hue_low) * hd_s);
    s3_nxt.p_ol       = 19'(19'(cfg_r.orange_hue_low) * hd_s);
  end

  always_ff @(posedge clk) begin
    if (en3) s3_r <= s3_nxt;
  end

  // stage 4: decision and output register
  pixel_class_t cls;
  pixel_class_t cls_r;
  pix_t         opix_r, opix_nxt;

  hslc_decide u_decide (
    .s3  (s3_r),
    .cfg (cfg_r),
    .cls (cls)
  );

  always_comb begin
    case (cls)
      CLASS_WHITE: opix_nxt = '{blue: 8'd255, green: 8'd255, red: 8'd255};
      CLASS_BLACK: opix_nxt = '{blue: 8'd0, green: 8'd0, red: 8'd0};
      default:     opix_nxt = s3_r.pix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      opix_r <= opix_nxt;
      cls_r  <= cls;
    end
  end

  assign out_pix.valid       = vo_r;
  assign out_pix.out_blue    = opix_r.blue;
  assign out_pix.out_green   = opix_r.green;
  assign out_pix.out_red     = opix_r.red;
  assign out_pix.pixel_class = cls_r;

  // an empty output register always lets a new word in
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vo_r |-> in_pix.ready)
    else $error("input stalled with empty output stage");

  // forced classes carry their fixed color
  a_white_color: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && cls_r == CLASS_WHITE |->
      opix_r.blue == 8'd255 && opix_r.green == 8'd255 && opix_r.red == 8'd255)
    else $error("white class without white pixel");

  a_black_color: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && cls_r == CLASS_BLACK |->
      opix_r.blue == 8'd0 && opix_r.green == 8'd0 && opix_r.red == 8'd0)
    else $error("black class without black pixel");

  // a held word in stage 3 is not dropped
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en3 |=> v3_r && $stable(s3_r))
    else $error("stage 3 word lost during stall");

  // grey pixels reach stage 2 as hue zero over a unit divisor
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && s2_r.grey |-> s2_r.hd == 8'd1 && s2_r.hn == 18'sd0)
    else $error("grey pixel with nonzero hue");

endmodule

`default_nettype wire
